### rtl/rpb_pkg.sv
// ----------------------------------------------------------------------------
// rpb_pkg
// Shared types and constants of the radial profile binner.
// ----------------------------------------------------------------------------
package rpb_pkg;

  localparam int NUM_BINS_DEF = 20;
  localparam int CFG_W        = 16;
  localparam int FIELD_W      = 24;
  localparam int CNT_W        = 16;
  localparam int SUM_W        = 40;
  localparam int BIN_W        = 6;
  localparam int QDEPTH       = 2;

  // register indexes
  localparam logic [1:0] REG_CELL_SIZE   = 2'd0;
  localparam logic [1:0] REG_BIN_WIDTH   = 2'd1;
  localparam logic [1:0] REG_GRID_OFFSET = 2'd2;

  localparam logic [CFG_W-1:0] CELL_SIZE_RST   = 16'd384;
  localparam logic [CFG_W-1:0] BIN_WIDTH_RST   = 16'd384;
  localparam logic [CFG_W-1:0] GRID_OFFSET_RST = 16'd9216;

  localparam logic CMD_ACC  = 1'b0;
  localparam logic CMD_EMIT = 1'b1;

  typedef struct packed {
    logic [CFG_W-1:0] cell_size;
    logic [CFG_W-1:0] bin_width;
    logic [CFG_W-1:0] grid_offset;
  } cfg_t;

  // classified item passed from front to back
  typedef struct packed {
    logic                      cmd;
    logic [BIN_W-1:0]          bin;
    logic signed [FIELD_W-1:0] temperature;
    logic [FIELD_W-1:0]        flow_mag;
    logic signed [FIELD_W-1:0] potential;
    logic signed [FIELD_W-1:0] strange;
  } qent_t;

  typedef struct packed {
    logic [CNT_W-1:0]        cnt;
    logic signed [SUM_W-1:0] st;
    logic signed [SUM_W-1:0] sf;
    logic signed [SUM_W-1:0] sp;
    logic signed [SUM_W-1:0] ss;
  } ent_t;

  typedef struct packed {
    logic [BIN_W-1:0]          bin_index;
    logic [FIELD_W-1:0]        bin_radius;
    logic [CNT_W-1:0]          sample_count;
    logic signed [FIELD_W-1:0] mean_temperature;
    logic [FIELD_W-1:0]        mean_flow;
    logic signed [FIELD_W-1:0] mean_potential;
    logic signed [FIELD_W-1:0] mean_strange;
    logic                      last;
  } rec_t;

endpackage

### rtl/rpb_front.sv
// ----------------------------------------------------------------------------
// rpb_front
// Accept items, find the radial bin and the flow magnitude of each sample.
// ----------------------------------------------------------------------------
module rpb_front import rpb_pkg::*; #(
  parameter int NUM_BINS = NUM_BINS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  cfg_t                      cfg,
  input  logic                      push,
  output logic                      full,
  input  logic                      cmd,
  input  logic [7:0]                cell_x,
  input  logic [7:0]                cell_y,
  input  logic signed [FIELD_W-1:0] temperature,
  input  logic signed [FIELD_W-1:0] flow_x,
  input  logic signed [FIELD_W-1:0] flow_y,
  input  logic signed [FIELD_W-1:0] potential,
  input  logic signed [FIELD_W-1:0] strange_potential,
  output logic                      q_push,
  input  logic                      q_full,
  output qent_t                     q_data
);

  localparam logic [2:0] F_IDLE  = 3'd0;
  localparam logic [2:0] F_COORD = 3'd1;
  localparam logic [2:0] F_SQ    = 3'd2;
  localparam logic [2:0] F_RUN   = 3'd3;
  localparam logic [2:0] F_PUSH  = 3'd4;

  logic [2:0]                fstate;
  logic                      cmd_r;
  logic [7:0]                cx, cy;
  logic signed [FIELD_W-1:0] temp_r, fx, fy, pot_r, str_r;
  logic signed [26:0]        x2, y2;
  logic [51:0]               s;
  logic [47:0]               v, res, bitv;
  logic [6:0]                k, ir;
  logic [22:0]               edge_len;
  logic                      sdone;

  logic [25:0]        px, py;
  logic signed [53:0] xsq, ysq;
  logic signed [47:0] fxsq, fysq;
  logic [45:0]        e2;
  logic [47:0]        trial;
  logic               ok, in_range;

  assign px    = 26'({cx, 1'b1}) * 26'(cfg.cell_size);
  assign py    = 26'({cy, 1'b1}) * 26'(cfg.cell_size);
  assign xsq   = x2 * x2;
  assign ysq   = y2 * y2;
  assign fxsq  = fx * fx;
  assign fysq  = fy * fy;
  assign e2    = 46'(edge_len) * 46'(edge_len);
  // odd edges are open, even edges closed: round half to even
  assign ok    = k[0] ? ({6'd0, e2} < s) : ({6'd0, e2} <= s);
  assign trial = res + bitv;
  assign in_range = (cmd_r == CMD_EMIT) || (ir < 7'(NUM_BINS));

  assign full   = (fstate != F_IDLE);
  assign q_push = (fstate == F_PUSH) && in_range && !q_full;

  always_comb begin
    q_data             = '0;
    q_data.cmd         = cmd_r;
    q_data.bin         = ir[BIN_W-1:0];
    q_data.temperature = temp_r;
    q_data.flow_mag    = res[FIELD_W-1:0];
    q_data.potential   = pot_r;
    q_data.strange     = str_r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fstate <= F_IDLE;
    end else begin
      case (fstate)
        F_IDLE: begin
          if (push) begin
            cmd_r  <= cmd;
            cx     <= cell_x;
            cy     <= cell_y;
            temp_r <= temperature;
            fx     <= flow_x;
            fy     <= flow_y;
            pot_r  <= potential;
            str_r  <= strange_potential;
            fstate <= (cmd == CMD_EMIT) ? F_PUSH : F_COORD;
          end
        end
        F_COORD: begin
          x2     <= $signed({1'b0, px}) - $signed({10'd0, cfg.grid_offset, 1'b0});
          y2     <= $signed({1'b0, py}) - $signed({10'd0, cfg.grid_offset, 1'b0});
          fstate <= F_SQ;
        end
        F_SQ: begin
          s        <= xsq[51:0] + ysq[51:0];
          v        <= fxsq + fysq;
          res      <= '0;
          bitv     <= 48'd1 << 46;
          k        <= 7'd1;
          ir       <= '0;
          edge_len <= 23'(cfg.bin_width);
          sdone    <= 1'b0;
          fstate   <= F_RUN;
        end
        F_RUN: begin
          // one edge test and one root digit a cycle
          if (!sdone) begin
            if (ok) begin
              ir <= k;
              if (k == 7'(NUM_BINS)) begin
                sdone <= 1'b1;
              end else begin
                k        <= k + 7'd1;
                edge_len <= edge_len + 23'({cfg.bin_width, 1'b0});
              end
            end else begin
              sdone <= 1'b1;
            end
          end
          if (bitv != '0) begin
            if (v >= trial) begin
              v   <= v - trial;
              res <= (res >> 1) + bitv;
            end else begin
              res <= res >> 1;
            end
            bitv <= bitv >> 2;
          end
          if (sdone && bitv == '0) begin
            fstate <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!in_range || !q_full) begin
            fstate <= F_IDLE;
          end
        end
        default: fstate <= F_IDLE;
      endcase
    end
  end

endmodule

### rtl/rpb_queue.sv
// ----------------------------------------------------------------------------
// rpb_queue
// Short FIFO between the classifying front and the accumulating back.
// ----------------------------------------------------------------------------
module rpb_queue import rpb_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr,
  input  qent_t wdata,
  output logic  full,
  input  logic  rd,
  output qent_t rdata,
  output logic  empty
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  qent_t          mem [QDEPTH];
  logic [PW-1:0]  wp, rp;
  logic [PW:0]    fill;

  assign full  = (fill == (PW+1)'(QDEPTH));
  assign empty = (fill == '0);
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wp] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      rp   <= '0;
      fill <= '0;
    end else begin
      if (wr) begin
        wp <= (wp == PW'(QDEPTH-1)) ? '0 : wp + 1'b1;
      end
      if (rd) begin
        rp <= (rp == PW'(QDEPTH-1)) ? '0 : rp + 1'b1;
      end
      fill <= fill + (PW+1)'(wr) - (PW+1)'(rd);
    end
  end

endmodule

### rtl/rpb_back.sv
// ----------------------------------------------------------------------------
// rpb_back
// Bin store with read-modify-write accumulate, and the emit scan with dividers.
// ----------------------------------------------------------------------------
module rpb_back import rpb_pkg::*; #(
  parameter int NUM_BINS = NUM_BINS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [CFG_W-1:0] bin_width,
  input  logic             q_empty,
  input  qent_t            q_data,
  output logic             q_pop,
  output logic             out_vld,
  output rec_t             out_rec,
  input  logic             pop
);

  localparam int AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

  localparam logic [2:0] B_IDLE   = 3'd0;
  localparam logic [2:0] B_ACC_RD = 3'd1;
  localparam logic [2:0] B_EM_RD  = 3'd2;
  localparam logic [2:0] B_EM_CHK = 3'd3;
  localparam logic [2:0] B_EM_DIV = 3'd4;
  localparam logic [2:0] B_EM_REC = 3'd5;
  localparam logic [2:0] B_EM_FIN = 3'd6;

  ent_t                mem [NUM_BINS];
  logic [NUM_BINS-1:0] valid;
  logic [2:0]          bstate;
  logic [AW-1:0]       rd_addr, cur_bin, scan;
  ent_t                rd_data;
  logic                rd_vld;
  qent_t               cur;
  logic [CNT_W-1:0]    cnt_r;
  logic [5:0]          div_cnt;
  logic [15:0]         rem [4];
  logic [SUM_W-1:0]    dq [4];
  logic                neg [4];
  logic [FIELD_W-1:0]  radius;
  rec_t                pend, new_rec, fin_rec;
  logic                has_pend;

  logic                we, push_out, push_fin, last_bin;
  ent_t                wdata;
  logic signed [SUM_W-1:0] lsum [4];
  logic [24:0]         rad_full;
  logic [FIELD_W-1:0]  mean [4];

  assign q_pop    = (bstate == B_IDLE) && !q_empty;
  assign rd_addr  = (bstate == B_IDLE) ? q_data.bin[AW-1:0] : scan;
  assign last_bin = (scan == AW'(NUM_BINS-1));
  assign rad_full = 25'({scan, 1'b1}) * 25'(bin_width) + 25'd1;

  // saturated bins ignore further samples
  assign we = (bstate == B_ACC_RD) && !(rd_vld && rd_data.cnt == '1);

  always_comb begin
    wdata = rd_vld ? rd_data : '0;
    wdata.cnt = wdata.cnt + 1'b1;
    wdata.st  = wdata.st + SUM_W'(cur.temperature);
    wdata.sf  = wdata.sf + $signed({16'd0, cur.flow_mag});
    wdata.sp  = wdata.sp + SUM_W'(cur.potential);
    wdata.ss  = wdata.ss + SUM_W'(cur.strange);
  end

  always_comb begin
    lsum[0] = rd_data.st;
    lsum[1] = rd_data.sf;
    lsum[2] = rd_data.sp;
    lsum[3] = rd_data.ss;
    for (int i = 0; i < 4; i++) begin
      mean[i] = neg[i] ? -dq[i][FIELD_W-1:0] : dq[i][FIELD_W-1:0];
    end
    new_rec                  = '0;
    new_rec.bin_index        = BIN_W'(scan);
    new_rec.bin_radius       = radius;
    new_rec.sample_count     = cnt_r;
    new_rec.mean_temperature = mean[0];
    new_rec.mean_flow        = mean[1];
    new_rec.mean_potential   = mean[2];
    new_rec.mean_strange     = mean[3];
    // final record of an emit: the held one, or all zero when no bin was filled
    fin_rec                  = has_pend ? pend : '0;
    fin_rec.last             = 1'b1;
  end

  assign push_fin = (bstate == B_EM_FIN) && !out_vld;
  assign push_out = push_fin || ((bstate == B_EM_REC) && has_pend && !out_vld);

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (we) begin
      mem[cur_bin] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bstate   <= B_IDLE;
      valid    <= '0;
      out_vld  <= 1'b0;
      has_pend <= 1'b0;
    end else begin
      rd_vld <= valid[rd_addr];
      if (pop && out_vld) begin
        out_vld <= 1'b0;
      end
      case (bstate)
        B_IDLE: begin
          if (!q_empty) begin
            cur      <= q_data;
            cur_bin  <= q_data.bin[AW-1:0];
            scan     <= '0;
            has_pend <= 1'b0;
            bstate   <= (q_data.cmd == CMD_EMIT) ? B_EM_RD : B_ACC_RD;
          end
        end
        B_ACC_RD: begin
          if (we) begin
            valid[cur_bin] <= 1'b1;
          end
          bstate <= B_IDLE;
        end
        B_EM_RD: bstate <= B_EM_CHK;
        B_EM_CHK: begin
          if (rd_vld) begin
            cnt_r   <= rd_data.cnt;
            radius  <= rad_full[24:1];
            div_cnt <= '0;
            for (int i = 0; i < 4; i++) begin
              neg[i] <= lsum[i][SUM_W-1];
              rem[i] <= '0;
              dq[i]  <= (lsum[i][SUM_W-1] ? -lsum[i] : lsum[i])
                        + SUM_W'(rd_data.cnt >> 1);
            end
            bstate <= B_EM_DIV;
          end else if (last_bin) begin
            bstate <= B_EM_FIN;
          end else begin
            scan   <= scan + 1'b1;
            bstate <= B_EM_RD;
          end
        end
        B_EM_DIV: begin
          // one quotient bit a cycle in each lane
          for (int i = 0; i < 4; i++) begin
            if ({rem[i], dq[i][SUM_W-1]} >= {1'b0, cnt_r}) begin
              rem[i] <= 16'({rem[i], dq[i][SUM_W-1]} - {1'b0, cnt_r});
              dq[i]  <= {dq[i][SUM_W-2:0], 1'b1};
            end else begin
              rem[i] <= {rem[i][14:0], dq[i][SUM_W-1]};
              dq[i]  <= {dq[i][SUM_W-2:0], 1'b0};
            end
          end
          div_cnt <= div_cnt + 6'd1;
          if (div_cnt == 6'(SUM_W-1)) begin
            bstate <= B_EM_REC;
          end
        end
        B_EM_REC: begin
          if (!has_pend || !out_vld) begin
            if (has_pend) begin
              out_vld <= 1'b1;
              out_rec <= pend;
            end
            pend     <= new_rec;
            has_pend <= 1'b1;
            if (last_bin) begin
              bstate <= B_EM_FIN;
            end else begin
              scan   <= scan + 1'b1;
              bstate <= B_EM_RD;
            end
          end
        end
        B_EM_FIN: begin
          if (!out_vld) begin
            out_vld <= 1'b1;
            out_rec <= fin_rec;
            valid   <= '0;
            bstate  <= B_IDLE;
          end
        end
        default: bstate <= B_IDLE;
      endcase
    end
  end

  a_clear_after_emit: assert property (@(posedge clk) disable iff (rst)
    push_fin |=> (valid == '0))
    else $error("bin store not cleared after emit");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    (bstate != B_IDLE) |-> (scan <= AW'(NUM_BINS-1)))
    else $error("scan index out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    push_out |-> !out_vld)
    else $error("result register overwritten");

  a_no_write_in_emit: assert property (@(posedge clk) disable iff (rst)
    (bstate != B_ACC_RD) |-> !we)
    else $error("store written outside accumulate");

endmodule

### rtl/radial_profile_binner_top.sv
// ----------------------------------------------------------------------------
// radial_profile_binner_top
// Radial histogram of grid samples with per-bin means, queue style ports.
// ----------------------------------------------------------------------------
// Push an item with cmd=0 to add a sample: the front places the cell centre
// relative to the grid centre, rounds its distance over bin_width to a bin
// (half to even) and takes the flow magnitude, and the back adds the sample
// to that bin. Push cmd=1 to get one record per non-empty bin in bin order,
// the last one flagged, after which all bins are empty; an emit over empty
// bins gives a single all-zero record with last set. A sample holds the
// front while it is taken, placed and squared, run through the digit-serial
// flow root (24 steps and one to see the end; the bin edge search, one edge
// a cycle, runs beside it and outlasts the root only when NUM_BINS exceeds
// 24) and handed on; the front takes no new sample until then, and the back
// updates its store with a read and a write. Emit reads and checks every
// bin; a filled bin also passes through the bit-serial mean dividers before
// its record. Registers: 0x0 cell_size, 0x4 bin_width,
// 0x8 grid_offset; write them only while the block is idle.
// ----------------------------------------------------------------------------
module radial_profile_binner_top import rpb_pkg::*; #(
  parameter int NUM_BINS = NUM_BINS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  // configuration
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [3:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  // items in
  input  logic                      push,
  output logic                      full,
  input  logic                      cmd,
  input  logic [7:0]                cell_x,
  input  logic [7:0]                cell_y,
  input  logic signed [FIELD_W-1:0] temperature,
  input  logic signed [FIELD_W-1:0] flow_x,
  input  logic signed [FIELD_W-1:0] flow_y,
  input  logic signed [FIELD_W-1:0] potential,
  input  logic signed [FIELD_W-1:0] strange_potential,
  // results out
  output logic                      empty,
  input  logic                      pop,
  output logic [BIN_W-1:0]          bin_index,
  output logic [FIELD_W-1:0]        bin_radius,
  output logic [CNT_W-1:0]          sample_count,
  output logic signed [FIELD_W-1:0] mean_temperature,
  output logic [FIELD_W-1:0]        mean_flow,
  output logic signed [FIELD_W-1:0] mean_potential,
  output logic signed [FIELD_W-1:0] mean_strange,
  output logic                      last
);

  cfg_t  cfg;
  logic  q_push, q_full, q_pop, q_empty, out_vld;
  qent_t q_wdata, q_rdata;
  rec_t  out_rec;

  // Register file: write on the access phase; unknown addresses drop the write.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cell_size   <= CELL_SIZE_RST;
      cfg.bin_width   <= BIN_WIDTH_RST;
      cfg.grid_offset <= GRID_OFFSET_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_CELL_SIZE:   cfg.cell_size   <= pwdata[CFG_W-1:0];
        REG_BIN_WIDTH:   cfg.bin_width   <= pwdata[CFG_W-1:0];
        REG_GRID_OFFSET: cfg.grid_offset <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_CELL_SIZE:   prdata = {16'd0, cfg.cell_size};
      REG_BIN_WIDTH:   prdata = {16'd0, cfg.bin_width};
      REG_GRID_OFFSET: prdata = {16'd0, cfg.grid_offset};
      default:         prdata = '0;
    endcase
  end

  // Front: classify each sample into a bin and compute its flow magnitude.
  rpb_front #(.NUM_BINS(NUM_BINS)) u_front (
    .clk, .rst, .cfg, .push, .full, .cmd, .cell_x, .cell_y, .temperature,
    .flow_x, .flow_y, .potential, .strange_potential,
    .q_push, .q_full, .q_data(q_wdata)
  );

  // Hold classified items so the front keeps working while the back is busy.
  rpb_queue u_queue (
    .clk, .rst, .wr(q_push), .wdata(q_wdata), .full(q_full),
    .rd(q_pop), .rdata(q_rdata), .empty(q_empty)
  );

  // Back: accumulate into the bin store, or scan and average on emit.
  rpb_back #(.NUM_BINS(NUM_BINS)) u_back (
    .clk, .rst, .bin_width(cfg.bin_width), .q_empty, .q_data(q_rdata),
    .q_pop, .out_vld, .out_rec, .pop
  );

  assign empty            = !out_vld;
  assign bin_index        = out_rec.bin_index;
  assign bin_radius       = out_rec.bin_radius;
  assign sample_count     = out_rec.sample_count;
  assign mean_temperature = out_rec.mean_temperature;
  assign mean_flow        = out_rec.mean_flow;
  assign mean_potential   = out_rec.mean_potential;
  assign mean_strange     = out_rec.mean_strange;
  assign last             = out_rec.last;

endmodule

### sim/radial_profile_binner_top_tb.sv
// ----------------------------------------------------------------------------
// radial_profile_binner_top_tb
// Self-checking bench: grid samples and emit commands go in through the queue
// port, every record coming out is compared with a bit-exact predictor of the
// radial histogram, across several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module radial_profile_binner_top_tb;
  import rpb_pkg::*;

  localparam int NBINS = NUM_BINS_DEF;
  localparam int SETTLE = 200;  // covers a sample still in flight in the front

  typedef struct {
    logic                      cmd;
    logic [7:0]                cx;
    logic [7:0]                cy;
    logic signed [FIELD_W-1:0] temp;
    logic signed [FIELD_W-1:0] fx;
    logic signed [FIELD_W-1:0] fy;
    logic signed [FIELD_W-1:0] pot;
    logic signed [FIELD_W-1:0] spot;
  } sample_t;

  // Histogram predictor plus the queue of records it still waits for.
  class profile_scoreboard;
    int unsigned cs, bw, go;
    int unsigned counts[NBINS];
    longint      s_temp[NBINS], s_flow[NBINS], s_pot[NBINS], s_str[NBINS];
    rec_t        pending[$];
    int          errors;

    function new();
      cs = CELL_SIZE_RST; bw = BIN_WIDTH_RST; go = GRID_OFFSET_RST;
      clear_bins();
      errors = 0;
    endfunction

    function void clear_bins();
      for (int b = 0; b < NBINS; b++) begin
        counts[b] = 0; s_temp[b] = 0; s_flow[b] = 0; s_pot[b] = 0; s_str[b] = 0;
      end
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] v);
      case (idx)
        REG_CELL_SIZE:   cs = v;
        REG_BIN_WIDTH:   bw = v;
        REG_GRID_OFFSET: go = v;
        default: ;
      endcase
    endfunction

    function longint unsigned flow_root(longint unsigned v);
      longint unsigned r, bt;
      r = 0;
      bt = 64'd1 << 62;
      while (bt > v) bt >>= 2;
      while (bt != 0) begin
        if (v >= r + bt) begin
          v -= r + bt;
          r = (r >> 1) + bt;
        end else begin
          r >>= 1;
        end
        bt >>= 2;
      end
      return r;
    endfunction

    function logic [23:0] round_mean(longint sum, int unsigned n);
      longint unsigned mag, q;
      mag = (sum < 0) ? -sum : sum;
      q = (mag + n / 2) / n;
      if (sum < 0) q = -q;
      return q[23:0];
    endfunction

    function longint centre_dist2(logic [7:0] idx);
      return longint'((2 * longint'(idx) + 1) * cs) - 2 * longint'(go);
    endfunction

    function void note(sample_t it);
      longint x2, y2, s, e;
      int ir;
      rec_t r;
      if (it.cmd == CMD_ACC) begin
        x2 = centre_dist2(it.cx);
        y2 = centre_dist2(it.cy);
        s = x2 * x2 + y2 * y2;
        ir = 0;
        // walk the bin edges; odd edges exclusive, even inclusive (ties to even)
        for (int k = 1; k <= NBINS; k++) begin
          e = longint'(2 * k - 1) * bw;
          if ((k % 2 == 1) ? !(e * e < s) : !(e * e <= s)) break;
          ir = k;
        end
        if (ir >= NBINS || counts[ir] >= 16'hFFFF) return;
        counts[ir]++;
        s_temp[ir] += it.temp;
        s_flow[ir] += longint'(flow_root(longint'(it.fx) * it.fx + longint'(it.fy) * it.fy));
        s_pot[ir]  += it.pot;
        s_str[ir]  += it.spot;
        return;
      end
      ir = pending.size();
      for (int b = 0; b < NBINS; b++) begin
        if (counts[b] == 0) continue;
        r = '0;
        r.bin_index        = BIN_W'(b);
        r.bin_radius       = FIELD_W'((longint'(2 * b + 1) * bw + 1) >> 1);
        r.sample_count     = CNT_W'(counts[b]);
        r.mean_temperature = round_mean(s_temp[b], counts[b]);
        r.mean_flow        = round_mean(s_flow[b], counts[b]);
        r.mean_potential   = round_mean(s_pot[b], counts[b]);
        r.mean_strange     = round_mean(s_str[b], counts[b]);
        pending.push_back(r);
      end
      if (pending.size() == ir) pending.push_back('0);
      pending[pending.size() - 1].last = 1'b1;
      clear_bins();
    endfunction

    function void check(rec_t got);
      rec_t w;
      if (pending.size() == 0) begin
        $error("record with nothing expected: bin_index %0d", got.bin_index);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (got.bin_index != w.bin_index) begin
        $error("bin_index exp %0d got %0d", w.bin_index, got.bin_index); errors++;
      end
      if (got.bin_radius != w.bin_radius) begin
        $error("bin_radius exp %0d got %0d", w.bin_radius, got.bin_radius); errors++;
      end
      if (got.sample_count != w.sample_count) begin
        $error("sample_count exp %0d got %0d", w.sample_count, got.sample_count); errors++;
      end
      if (got.mean_temperature != w.mean_temperature) begin
        $error("mean_temperature exp %0d got %0d", w.mean_temperature, got.mean_temperature);
        errors++;
      end
      if (got.mean_flow != w.mean_flow) begin
        $error("mean_flow exp %0d got %0d", w.mean_flow, got.mean_flow); errors++;
      end
      if (got.mean_potential != w.mean_potential) begin
        $error("mean_potential exp %0d got %0d", w.mean_potential, got.mean_potential);
        errors++;
      end
      if (got.mean_strange != w.mean_strange) begin
        $error("mean_strange exp %0d got %0d", w.mean_strange, got.mean_strange); errors++;
      end
      if (got.last != w.last) begin
        $error("last exp %0d got %0d", w.last, got.last); errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic psel, penable, pwrite;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic push, full, cmd;
  logic [7:0] cell_x, cell_y;
  logic signed [FIELD_W-1:0] temperature, flow_x, flow_y, potential, strange_potential;
  logic empty, pop;
  logic [BIN_W-1:0] bin_index;
  logic [FIELD_W-1:0] bin_radius;
  logic [CNT_W-1:0] sample_count;
  logic signed [FIELD_W-1:0] mean_temperature, mean_potential, mean_strange;
  logic [FIELD_W-1:0] mean_flow;
  logic last;

  radial_profile_binner_top dut (.*);

  profile_scoreboard sb;
  bit hold_req;    // ask the reader for one long hold-off
  bit calm_out;    // reader takes records back to back
  bit calm_in;     // writer offers items back to back

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Give up on a hung block.
  initial begin
    #30_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic int draw_gap(bit calm);
    return calm ? 0 : $urandom_range(0, 13);
  endfunction

  // Random 24-bit value, with the extremes and zero weighted in.
  function automatic logic signed [23:0] rand_q(bit hit_edges);
    case ($urandom_range(0, hit_edges ? 7 : 15))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2: return '0;
      default: return 24'($urandom());
    endcase
  endfunction

  // Register write: setup cycle, then access cycle; called right after an edge.
  task automatic reg_write(logic [1:0] idx, logic [15:0] v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= {16'h0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sb.set_reg(idx, v);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one item after a drawn gap and hold it until the block takes it.
  task automatic send(sample_t it);
    int gap;
    gap = draw_gap(calm_in);
    if ($urandom_range(0, 19) == 0) calm_in = ~calm_in;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    cmd <= it.cmd; cell_x <= it.cx; cell_y <= it.cy;
    temperature <= it.temp; flow_x <= it.fx; flow_y <= it.fy;
    potential <= it.pot; strange_potential <= it.spot;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note(it);
  endtask

  // Drop push and wait until every expected record is out, then let the
  // front drain any sample that yields nothing.
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic sample_t make_sample(bit emit, bit hit_edges);
    sample_t it;
    int ctr, span;
    it.cmd  = emit ? CMD_EMIT : CMD_ACC;
    it.temp = rand_q(hit_edges); it.fx = rand_q(hit_edges); it.fy = rand_q(hit_edges);
    it.pot  = rand_q(hit_edges); it.spot = rand_q(hit_edges);
    // Most samples land near the grid centre so the bins fill.
    ctr  = sb.go / sb.cs;
    span = (NBINS * sb.bw) / sb.cs + 2;
    if (ctr > 255) ctr = 255;
    if (span > 255) span = 255;
    if ($urandom_range(0, 3) == 0) begin
      it.cx = 8'($urandom()); it.cy = 8'($urandom());
    end else begin
      it.cx = 8'((ctr + $urandom_range(0, 2 * span) - span) & 8'hFF);
      it.cy = 8'((ctr + $urandom_range(0, 2 * span) - span) & 8'hFF);
    end
    return it;
  endfunction

  // Reader: take records after random gaps, with one long hold on request.
  initial begin
    int gap;
    pop = 1'b0;
    @(negedge rst);
    @(posedge clk);
    forever begin
      gap = draw_gap(calm_out);
      if ($urandom_range(0, 19) == 0) calm_out = ~calm_out;
      if (hold_req) begin
        hold_req = 1'b0;
        gap = 600;
      end
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      sb.check('{bin_index, bin_radius, sample_count, mean_temperature, mean_flow,
                 mean_potential, mean_strange, last});
    end
  end

  initial begin
    sample_t it;
    static int unsigned settings[5][3] = '{
      '{384, 384, 9216}, '{1, 1, 0}, '{65535, 65535, 65535},
      '{256, 512, 8192}, '{700, 100, 30000}};
    sb = new();
    rst = 1'b1;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    push = 0; cmd = 0; cell_x = 0; cell_y = 0;
    temperature = 0; flow_x = 0; flow_y = 0; potential = 0; strange_potential = 0;
    hold_req = 0; calm_in = 0; calm_out = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: emit over empty bins, then centre, edges and far corners.
    it = make_sample(1, 1);
    send(it);
    it = '{CMD_ACC, 8'd23, 8'd23, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF,
           24'sh7FFFFF, 24'sh7FFFFF};
    send(it);
    it = '{CMD_ACC, 8'd24, 8'd24, 24'sh800000, 24'sh800000, 24'sh800000,
           24'sh800000, 24'sh800000};
    send(it);
    it = '{CMD_ACC, 8'd0, 8'd0, 24'sh1, 24'sh0, 24'sh3, 24'sh1, 24'sh0};
    send(it);                                  // beyond the last bin
    it = '{CMD_ACC, 8'd255, 8'd255, 24'sh1, 24'sh5, 24'sh0, 24'sh1, 24'sh0};
    send(it);
    it = '{CMD_ACC, 8'd24, 8'd5, -24'sh3, 24'sh3, 24'sh4, -24'sh1, 24'sh2};
    send(it);
    it = '{CMD_ACC, 8'd24, 8'd5, 24'sh0, 24'sh0, 24'sh0, 24'sh0, 24'sh0};
    send(it);                                  // means land on a half
    it = '{CMD_ACC, 8'd43, 8'd24, 24'sh55AA55, -24'sh1, 24'sh1, 24'sh2AAAAA, -24'sh7};
    send(it);
    it = '{CMD_EMIT, 8'hFF, 8'hFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF,
           24'sh7FFFFF, 24'sh7FFFFF};
    send(it);                                  // sample fields ignored on emit
    it = '{CMD_EMIT, 8'h0, 8'h0, 24'sh0, 24'sh0, 24'sh0, 24'sh0, 24'sh0};
    send(it);
    drain();
    reg_write(2'd3, 16'hFFFF);                 // no such register: ignored

    // Random phases over several settings, the extremes among them.
    for (int ph = 0; ph < 5; ph++) begin
      reg_write(REG_CELL_SIZE, 16'(settings[ph][0]));
      reg_write(REG_BIN_WIDTH, 16'(settings[ph][1]));
      reg_write(REG_GRID_OFFSET, 16'(settings[ph][2]));
      if (ph == 1) hold_req = 1'b1;            // reader stalls; block backs up
      for (int n = 0; n < 44; n++) begin
        it = make_sample($urandom_range(0, 11) == 0, 0);
        send(it);
      end
      it = make_sample(1, 0);
      send(it);
      drain();                                 // writer waits for every record
    end

    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
